// ----- rtl/isotropic_tv_shrinkage_assert.svh -----
// Assertion macros for the shrinkage block
`ifndef ISOTROPIC_TV_SHRINKAGE_ASSERT_SVH
`define ISOTROPIC_TV_SHRINKAGE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ITS_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ITS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ITS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define ITS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/itvs_pkg.sv -----
`default_nettype none
package itvs_pkg;
   localparam int DATA_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int THR_WIDTH      = 23;
   localparam int CSR_ADDR_WIDTH = 1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_THRESHOLD = 1'b0;
endpackage
`default_nettype wire

// ----- rtl/itvs_pipe.sv -----
`default_nettype none
// Generic stall-able pipeline: stage k moves when it is empty or stage k+1 moves.
module itvs_pipe #(
   parameter int DATA_WIDTH = itvs_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic signed [DATA_WIDTH-1:0] in_x,
   input  wire logic signed [DATA_WIDTH-1:0] in_y,
   input  wire logic        [DATA_WIDTH-2:0] thr,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic signed [DATA_WIDTH-1:0]      out_x,
   output logic signed [DATA_WIDTH-1:0]      out_y
);
   localparam int W   = DATA_WIDTH;
   localparam int SW  = 2 * W;           // sum of squares width
   localparam int MW  = W;               // magnitude width (sqrt of 2W bits)
   localparam int SQS = W;               // sqrt steps, one result bit each
   localparam int PW  = 2 * W;           // product width for division
   localparam int DVS = W;               // quotient bits
   localparam int NS  = 1 + SQS + 1 + DVS + 1;
   localparam int SQ0 = 1;
   localparam int DV0 = SQ0 + SQS;
   localparam int LST = NS - 1;

   localparam logic [1:0] MODE_SCALE = 2'd0;
   localparam logic [1:0] MODE_PASS  = 2'd1;
   localparam logic [1:0] MODE_ZERO  = 2'd2;

   typedef struct packed {
      logic                 neg_x;
      logic                 neg_y;
      logic [W-1:0]         ax;
      logic [W-1:0]         ay;
      logic signed [W-1:0]  gx;
      logic signed [W-1:0]  gy;
      logic [W-2:0]         t;
      logic [SW-1:0]        rem;      // sqrt remainder / sum
      logic [MW-1:0]        root;
      logic [PW-1:0]        px;       // dividend x, shifted out msb first
      logic [PW-1:0]        py;
      logic [MW:0]          rx;       // division remainders
      logic [MW:0]          ry;
      logic [W-1:0]         qx;
      logic [W-1:0]         qy;
      logic [1:0]           mode;     // scale, pass or zero
   } stage_type;

   stage_type data_ff [NS];
   stage_type data_in [NS];
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] move;

   always_comb begin
      move[LST] = !valid_ff[LST] || out_ready;
      for (int k = LST - 1; k >= 0; k--) begin
         move[k] = !valid_ff[k] || move[k+1];
      end
   end
   assign in_ready  = move[0];
   assign out_valid = valid_ff[LST];

   always_comb begin
      logic [SW-1:0] tr;
      logic [SW-1:0] bitv;
      logic [MW:0]   dx;
      logic [MW:0]   dy;
      logic [MW:0]   m1;
      stage_type     s;
      for (int k = 0; k < NS; k++) begin
         data_in[k] = '0;
      end
      // stage 0: absolute values and sum of squares
      s       = '0;
      s.gx    = in_x;
      s.gy    = in_y;
      s.t     = thr;
      s.neg_x = in_x[W-1];
      s.neg_y = in_y[W-1];
      s.ax    = in_x[W-1] ? W'(-in_x) : W'(in_x);
      s.ay    = in_y[W-1] ? W'(-in_y) : W'(in_y);
      s.rem   = SW'(s.ax * s.ax) + SW'(s.ay * s.ay);
      data_in[0] = s;
      // restoring square root, one result bit per stage
      for (int k = 0; k < SQS; k++) begin
         s    = data_ff[SQ0 - 1 + k];
         bitv = SW'(1) << (2 * (SQS - 1 - k));
         tr   = (SW'(s.root) << (2 * (SQS - k))) | bitv;
         s.root = s.root << 1;
         if (s.rem >= tr) begin
            s.rem  = s.rem - tr;
            s.root = s.root | MW'(1);
         end
         data_in[SQ0 + k] = s;
      end
      // mode select and dividend products
      s  = data_ff[DV0 - 1];
      m1 = {1'b0, s.root} - {1'b0, (MW)'(s.t)};
      if (s.t == '0) begin
         s.mode = MODE_PASS;
      end else if (m1[MW] || m1 == '0) begin
         s.mode = MODE_ZERO;
      end else begin
         s.mode = MODE_SCALE;
      end
      s.px = PW'(s.ax) * PW'(m1[MW-1:0]);
      s.py = PW'(s.ay) * PW'(m1[MW-1:0]);
      s.rx = '0;
      s.ry = '0;
      s.qx = '0;
      s.qy = '0;
      data_in[DV0] = s;
      // restoring division: quotient < 2^W since root - t < root
      for (int k = 0; k < DVS; k++) begin
         s  = data_ff[DV0 + k];
         if (k == 0) begin
            // preload high W bits; they are below the divisor
            s.rx = {1'b0, s.px[PW-1 -: W]};
            s.ry = {1'b0, s.py[PW-1 -: W]};
         end
         dx = {s.rx[MW-1:0], s.px[W-1-k]};
         dy = {s.ry[MW-1:0], s.py[W-1-k]};
         s.qx = s.qx << 1;
         s.qy = s.qy << 1;
         if (s.root != '0 && dx >= {1'b0, s.root}) begin
            dx = dx - {1'b0, s.root};
            s.qx[0] = 1'b1;
         end
         if (s.root != '0 && dy >= {1'b0, s.root}) begin
            dy = dy - {1'b0, s.root};
            s.qy[0] = 1'b1;
         end
         s.rx = dx;
         s.ry = dy;
         data_in[DV0 + 1 + k] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (move[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (move[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < LST; k++) begin
         if (move[k]) begin
            data_ff[k] <= data_in[k];
         end
      end
      if (move[LST]) begin
         data_ff[LST] <= data_ff[LST-1];
      end
   end

   always_comb begin
      stage_type f;
      f = data_ff[LST];
      unique case (f.mode)
         MODE_PASS: begin
            out_x = f.gx;
            out_y = f.gy;
         end
         MODE_ZERO: begin
            out_x = '0;
            out_y = '0;
         end
         default: begin
            out_x = f.neg_x ? W'(-f.qx) : f.qx;
            out_y = f.neg_y ? W'(-f.qy) : f.qy;
         end
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/isotropic_tv_shrinkage.sv -----
`default_nettype none
// Isotropic TV shrinkage: one gradient pixel (grad_x, grad_y) in, one shrunk
// pixel out. Input transfers on req_valid & req_ready, results on
// rsp_valid & rsp_ready.
// Stages: one squaring stage, one stage per root bit of the square root,
// one product stage, one stage per quotient bit of the divider and one
// output register.
// Throughput: one pixel per cycle while rsp_ready is high.
// When rsp_ready is low the pipeline fills and stalls stage by stage; bubbles
// are squeezed out, nothing is lost or duplicated; req_ready drops only when
// every stage holds a pixel.
// Reset clears all valid bits and sets the threshold to zero (pass-through).
// The threshold register (offset 0) is written over the csr_ APB port and
// should only change while the pipeline is empty.
module isotropic_tv_shrinkage #(
   parameter int DATA_WIDTH = itvs_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = itvs_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [DATA_WIDTH-1:0]          req_grad_x,
   input  wire logic signed [DATA_WIDTH-1:0]          req_grad_y,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [DATA_WIDTH-1:0]               rsp_shrunk_x,
   output logic signed [DATA_WIDTH-1:0]               rsp_shrunk_y,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [itvs_pkg::CSR_ADDR_WIDTH+1:0]   csr_paddr,
   input  wire logic [31:0]                           csr_pwdata,
   output logic [31:0]                                csr_prdata,
   output logic                                       csr_pready
);
`include "isotropic_tv_shrinkage_assert.svh"
   // FRAC_BITS sets only the fixed-point interpretation; sqrt of Q(2F) is Q(F)
   localparam int FRAC_CHK = FRAC_BITS;

   logic [itvs_pkg::THR_WIDTH-1:0] threshold_ff;
   logic [itvs_pkg::THR_WIDTH-1:0] threshold_in;
   logic                           csr_wr;
   logic                           csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit = csr_paddr[itvs_pkg::CSR_ADDR_WIDTH+1:2] == itvs_pkg::REG_THRESHOLD;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_hit;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_wr) begin
         threshold_in = csr_pwdata[itvs_pkg::THR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = 32'(threshold_ff);
      end
   end

   // only the low DATA_WIDTH-1 threshold bits take part
   logic [DATA_WIDTH-2:0] thr;
   always_comb begin
      thr = '0;
      for (int i = 0; i < DATA_WIDTH - 1; i++) begin
         if (i < itvs_pkg::THR_WIDTH && FRAC_CHK >= 0) begin
            thr[i] = threshold_ff[i % itvs_pkg::THR_WIDTH];
         end
      end
   end

   itvs_pipe #(.DATA_WIDTH(DATA_WIDTH)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_grad_x),
      .in_y      (req_grad_y),
      .thr       (thr),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_x     (rsp_shrunk_x),
      .out_y     (rsp_shrunk_y)
   );

   `ITS_ASSERT_IMPL(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shrunk_x), "result dropped under stall")
   `ITS_ASSERT_IMPL(a_ready_free, clock, reset,
      !rsp_valid |-> req_ready, "input blocked with empty output")
   `ITS_ASSERT_ALWAYS(a_reset_idle, clock,
      !reset && $past(reset) |-> !rsp_valid, "result valid after reset")
endmodule
`default_nettype wire
